// File: src/cdenc_pkg.sv
package cdenc_pkg;

	localparam int MAX_COLUMNS_DEF     = 16;
	localparam int MAX_VALUES_DEF      = 16;
	localparam int MAX_TOKEN_BYTES_DEF = 8;

	localparam int CFG_W       = 5;
	localparam int COL_W       = 6;
	localparam int LEN_W       = 4;
	localparam int TOKW        = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_ADDED    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_SHORT    = 3'd4;

	localparam logic [7:0] SEP_SPACE = 8'h20;
	localparam logic [7:0] SEP_COMMA = 8'h2C;
	localparam logic [7:0] SEP_TAB   = 8'h09;
	localparam logic [7:0] SEP_LF    = 8'h0A;
	localparam logic [7:0] SEP_CR    = 8'h0D;

	typedef struct packed {
		logic             tok;
		logic             ovf;
		logic             short_row;
		logic [COL_W-1:0] col_tok;
		logic [COL_W-1:0] col_short;
		logic [LEN_W-1:0] len;
		logic [TOKW-1:0]  bytes;
	} cmd_t;

endpackage

// File: src/cdenc_front.sv
module cdenc_front #(
	parameter int MAX_COLUMNS     = cdenc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_TOKEN_BYTES = cdenc_pkg::MAX_TOKEN_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   byte_in,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cdenc_pkg::CFG_W-1:0]  num_columns,
	input  logic                         q_full,
	output logic                         cmd_push,
	output cdenc_pkg::cmd_t              cmd
);
	import cdenc_pkg::*;

	localparam int TW   = 8 * MAX_TOKEN_BYTES;
	localparam int CC_W = $clog2(MAX_COLUMNS + 1);

	logic [TW-1:0]    tok_q, tok_ins;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [CC_W-1:0]  cur_col_q, col_b;
	logic             is_sep, is_lf, accept, tok_active, ok_a, ok_b, emit_tok, emit_short;

	assign is_lf  = byte_in == SEP_LF;
	assign is_sep = byte_in == SEP_SPACE || byte_in == SEP_COMMA || byte_in == SEP_TAB ||
		is_lf || byte_in == SEP_CR;
	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign tok_active = (len_q != '0) || ovf_q;

	always_comb begin
		tok_ins = tok_q;
		for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
			if (len_q == LEN_W'(i))
				tok_ins[8*i +: 8] = byte_in;
		end
	end

	always_comb begin
		col_b = cur_col_q;
		if (tok_active && cur_col_q < CC_W'(MAX_COLUMNS))
			col_b = cur_col_q + CC_W'(1);
	end

	assign ok_a = (8'(cur_col_q) < 8'(num_columns)) && (8'(cur_col_q) < 8'(MAX_COLUMNS));
	assign ok_b = (8'(col_b) < 8'(num_columns)) && (8'(col_b) < 8'(MAX_COLUMNS));
	assign emit_tok   = tok_active && ok_a;
	assign emit_short = is_lf && ok_b;

	assign cmd_push      = accept && is_sep && (emit_tok || emit_short);
	assign cmd.tok       = emit_tok;
	assign cmd.ovf       = ovf_q;
	assign cmd.short_row = emit_short;
	assign cmd.col_tok   = COL_W'(cur_col_q);
	assign cmd.col_short = COL_W'(col_b);
	assign cmd.len       = len_q;
	assign cmd.bytes     = TOKW'(tok_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q     <= '0;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			cur_col_q <= '0;
		end else if (accept) begin
			if (!is_sep) begin
				if (len_q < LEN_W'(MAX_TOKEN_BYTES)) begin
					tok_q <= tok_ins;
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else begin
				// separator closes any open token; LF also restarts the row
				tok_q     <= '0;
				len_q     <= '0;
				ovf_q     <= 1'b0;
				cur_col_q <= is_lf ? '0 : col_b;
			end
		end
	end

endmodule

// File: src/cdenc_queue.sv
module cdenc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cdenc_pkg::cmd_t wdata,
	input  logic            pop,
	output cdenc_pkg::cmd_t rdata,
	output logic            not_empty,
	output logic            full
);
	import cdenc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push, do_pop;

	assign not_empty = count_q != '0;
	assign full      = count_q == NW'(QUEUE_DEPTH);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + NW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - NW'(1);
		end
	end

endmodule

// File: src/cdenc_back.sv
module cdenc_back #(
	parameter int MAX_COLUMNS     = cdenc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_VALUES      = cdenc_pkg::MAX_VALUES_DEF,
	parameter int MAX_TOKEN_BYTES = cdenc_pkg::MAX_TOKEN_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cdenc_pkg::cmd_t cmd,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [3:0]      column,
	output logic [3:0]      value_index,
	output logic [2:0]      status,
	output logic            last
);
	import cdenc_pkg::*;

	localparam int CIX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int IX_W  = $clog2(MAX_VALUES);
	localparam int CN_W  = $clog2(MAX_VALUES + 1);
	localparam int DEPTH = MAX_COLUMNS * MAX_VALUES;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = 8 * MAX_TOKEN_BYTES;
	localparam int EW    = TW + LEN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_CNT  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]       state_q;
	cmd_t             cmd_q;
	logic [IX_W-1:0]  idx_q;
	logic [CN_W-1:0]  cnt_q;
	logic [COL_W-1:0] res_col_q;
	logic [IX_W-1:0]  res_idx_q;
	logic [2:0]       res_st_q;
	logic             res_last_q, short_pend_q;

	logic [EW-1:0]    ent_mem [DEPTH];
	logic [EW-1:0]    ent_rd_q;
	logic [CN_W-1:0]  cnt_mem [MAX_COLUMNS];
	logic [CN_W-1:0]  cnt_rd_q;
	logic [MAX_COLUMNS-1:0] vld_q;

	logic             out_valid_q, last_out_q;
	logic [3:0]       col_out_q, idx_out_q;
	logic [2:0]       st_out_q;

	logic [CIX_W-1:0] col_ix;
	logic [AW-1:0]    base, rd_addr, wr_addr;
	logic [CN_W-1:0]  cnt_now, new_cnt;
	logic [EW-1:0]    key;
	logic [7:0]       res_idx_wide;
	logic             hit, last_idx, miss, add, slot_free;

	assign col_ix    = cmd_q.col_tok[CIX_W-1:0];
	assign base      = AW'(col_ix) * AW'(MAX_VALUES);
	assign rd_addr   = base + AW'(idx_q);
	assign cnt_now   = vld_q[col_ix] ? cnt_rd_q : '0;
	assign new_cnt   = (state_q == S_CNT) ? cnt_now : cnt_q;
	assign wr_addr   = base + AW'(new_cnt);
	assign key       = {cmd_q.len, cmd_q.bytes[TW-1:0]};
	assign hit       = ent_rd_q == key;
	assign last_idx  = (CN_W'(idx_q) + CN_W'(1)) == cnt_q;
	assign miss      = (state_q == S_CNT && cnt_now == '0) ||
		(state_q == S_CMP && !hit && last_idx);
	assign add       = miss && (new_cnt < CN_W'(MAX_VALUES));
	assign slot_free = !out_valid_q || out_ready;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res_idx_wide = 8'(res_idx_q);

	// dictionary entries and per-column fill counts
	always_ff @(posedge clk) begin
		if (add) begin
			ent_mem[wr_addr] <= key;
			cnt_mem[col_ix]  <= new_cnt + CN_W'(1);
		end
		ent_rd_q <= ent_mem[rd_addr];
		cnt_rd_q <= cnt_mem[col_ix];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			res_col_q    <= '0;
			res_idx_q    <= '0;
			res_st_q     <= ST_FOUND;
			res_last_q   <= 1'b0;
			short_pend_q <= 1'b0;
			vld_q        <= '0;
		end else begin
			if (add)
				vld_q[col_ix] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_idx_q    <= '0;
						short_pend_q <= cmd.tok && cmd.short_row;
						if (cmd.tok) begin
							res_col_q  <= cmd.col_tok;
							res_st_q   <= ST_TOO_LONG;
							res_last_q <= !cmd.short_row;
							state_q    <= cmd.ovf ? S_OUT : S_LOOK;
						end else begin
							res_col_q  <= cmd.col_short;
							res_st_q   <= ST_SHORT;
							res_last_q <= 1'b1;
							state_q    <= S_OUT;
						end
					end
				end
				S_LOOK: state_q <= S_CNT;
				S_CNT: begin
					cnt_q <= cnt_now;
					idx_q <= '0;
					if (cnt_now == '0) begin
						res_st_q  <= ST_ADDED;
						res_idx_q <= '0;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (hit) begin
						res_st_q  <= ST_FOUND;
						res_idx_q <= idx_q;
						state_q   <= S_OUT;
					end else if (last_idx) begin
						res_st_q  <= add ? ST_ADDED : ST_FULL;
						res_idx_q <= add ? IX_W'(cnt_q) : '0;
						state_q   <= S_OUT;
					end else begin
						idx_q   <= idx_q + IX_W'(1);
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						if (short_pend_q) begin
							// token result goes out first, then the short-row result
							short_pend_q <= 1'b0;
							res_col_q    <= cmd_q.col_short;
							res_idx_q    <= '0;
							res_st_q     <= ST_SHORT;
							res_last_q   <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= state_q == S_OUT;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && state_q == S_OUT) begin
			col_out_q  <= res_col_q[3:0];
			idx_out_q  <= res_idx_wide[3:0];
			st_out_q   <= res_st_q;
			last_out_q <= res_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign column      = col_out_q;
	assign value_index = idx_out_q;
	assign status      = st_out_q;
	assign last        = last_out_q;

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_out_q == ST_SHORT |-> last_out_q)
		else $error("short-row result without last");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> CN_W'(idx_q) < cnt_q)
		else $error("dictionary scan past fill count");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q != S_IDLE)
		else $error("popped command not started");

	a_add_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		add |-> (state_q == S_CNT || state_q == S_CMP) && new_cnt < CN_W'(MAX_VALUES))
		else $error("dictionary write while full");

endmodule

// File: src/csv_column_dictionary_encoder_top.sv
// Path: a separator's command passes the command queue, then the dictionary unit's states IDLE,
//   LOOK, CNT (on to OUT if the column dictionary is empty), RD and CMP per stored entry scanned
//   (one entry memory read), then OUT. Token bytes are taken 1 per cycle while the command queue
//   is not full; a 2-deep command queue absorbs token ends. An overlong token or a lone short-row
//   result goes from IDLE to OUT; a short-row result after a token makes a second OUT pass.
// Reset: clears the open token, the column count of the row, all dictionaries
//   (per-column valid flags) and the queue; num_columns returns to 1.
module csv_column_dictionary_encoder_top #(
	parameter int MAX_COLUMNS     = cdenc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_VALUES      = cdenc_pkg::MAX_VALUES_DEF,
	parameter int MAX_TOKEN_BYTES = cdenc_pkg::MAX_TOKEN_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cdenc_pkg::CFG_W-1:0] cfg_wdata,
	input  logic [7:0]                  byte_in,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic [3:0]                  column,
	output logic [3:0]                  value_index,
	output logic [2:0]                  status,
	output logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import cdenc_pkg::*;

	logic [CFG_W-1:0] num_columns_q;
	cmd_t             push_cmd, head_cmd;
	logic             push, pop, q_full, q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_columns_q <= CFG_W'(1);
		else if (cfg_we)
			num_columns_q <= cfg_wdata;
	end

	cdenc_front #(
		.MAX_COLUMNS     (MAX_COLUMNS),
		.MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.num_columns (num_columns_q),
		.q_full      (q_full),
		.cmd_push    (push),
		.cmd         (push_cmd)
	);

	cdenc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_cmd),
		.pop       (pop),
		.rdata     (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	cdenc_back #(
		.MAX_COLUMNS     (MAX_COLUMNS),
		.MAX_VALUES      (MAX_VALUES),
		.MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_valid   (q_not_empty),
		.cmd_pop     (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.column      (column),
		.value_index (value_index),
		.status      (status),
		.last        (last)
	);

endmodule

// File: test/tb_csv_column_dictionary_encoder_top.sv
`timescale 1ns / 100ps

module tb_csv_column_dictionary_encoder_top;
	import cdenc_pkg::*;

	localparam int NCOL_MAX      = 16;
	localparam int NVAL_MAX      = 16;
	localparam int TOK_MAX       = 8;
	localparam int POOL_SIZE     = 24;
	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_BYTES   = 80;

	typedef struct packed {
		logic [3:0] column;
		logic [3:0] value_index;
		logic [2:0] status;
		logic       last;
	} code_t;

	typedef struct {
		logic [7:0] data;
		bit         hold;
	} text_byte_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata   = '0;
	logic [7:0]          byte_in     = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [3:0]          column;
	logic [3:0]          value_index;
	logic [2:0]          status;
	logic                last;
	logic                out_valid;
	logic                out_ready   = 1'b0;

	csv_column_dictionary_encoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_in    (byte_in),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.column     (column),
		.value_index(value_index),
		.status     (status),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	// encoder state as predicted
	logic [63:0]      tok_word;
	int               tok_len;
	bit               tok_ovf;
	int               row_col;
	int               dict_cnt  [NCOL_MAX];
	logic [63:0]      dict_word [NCOL_MAX][NVAL_MAX];
	int               dict_len  [NCOL_MAX][NVAL_MAX];
	logic [CFG_W-1:0] ncols_cfg;

	code_t      expected_codes[$];
	text_byte_t text_stream[$];

	logic [63:0] pool_word[POOL_SIZE];
	int          pool_len [POOL_SIZE];

	int    mismatches;
	int    send_wait;
	int    stall_left;
	int    quiet_cycles;
	bit    no_idle;
	logic  next_in_valid;
	logic  next_out_ready;
	code_t seen;
	code_t want;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit is_break_byte(input logic [7:0] b);
		return b == SEP_SPACE || b == SEP_COMMA || b == SEP_TAB || b == SEP_LF || b == SEP_CR;
	endfunction

	function automatic int active_columns();
		return (ncols_cfg > NCOL_MAX) ? NCOL_MAX : int'(ncols_cfg);
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic void push_code(input int col, input int idx, input logic [2:0] st);
		code_t c;
		c.column      = col[3:0];
		c.value_index = idx[3:0];
		c.status      = st;
		c.last        = 1'b0;
		expected_codes.push_back(c);
	endfunction

	// advance the predicted encoder by one accepted byte
	function automatic void encode_byte(input logic [7:0] b);
		int n_cols;
		int hit;
		int cnt;
		int produced;
		n_cols   = active_columns();
		produced = 0;
		if (!is_break_byte(b)) begin
			if (tok_len < TOK_MAX) begin
				tok_word[8*tok_len +: 8] = b;
				tok_len++;
			end else begin
				tok_ovf = 1'b1;
			end
			return;
		end
		if (tok_len > 0 || tok_ovf) begin
			if (row_col < n_cols) begin
				if (tok_ovf) begin
					push_code(row_col, 0, ST_TOO_LONG);
				end else begin
					cnt = dict_cnt[row_col];
					hit = -1;
					for (int i = 0; i < cnt; i++)
						if (hit < 0 && dict_len[row_col][i] == tok_len &&
						    dict_word[row_col][i] == tok_word)
							hit = i;
					if (hit >= 0) begin
						push_code(row_col, hit, ST_FOUND);
					end else if (cnt < NVAL_MAX) begin
						dict_word[row_col][cnt] = tok_word;
						dict_len[row_col][cnt]  = tok_len;
						dict_cnt[row_col]       = cnt + 1;
						push_code(row_col, cnt, ST_ADDED);
					end else begin
						push_code(row_col, 0, ST_FULL);
					end
				end
				produced++;
			end
			if (row_col < NCOL_MAX)
				row_col++;
			tok_word = '0;
			tok_len  = 0;
			tok_ovf  = 1'b0;
		end
		if (b == SEP_LF) begin
			if (row_col < n_cols) begin
				push_code(row_col, 0, ST_SHORT);
				produced++;
			end
			row_col = 0;
		end
		if (produced > 0)
			expected_codes[$].last = 1'b1;
	endfunction

	// input side: present queued bytes, predict on each transaction
	always @(posedge clk) begin
		next_in_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				encode_byte(byte_in);
				next_in_valid = 1'b0;
				send_wait     = draw_gap();
			end
			if (!next_in_valid && text_stream.size() > 0) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (!(text_stream[0].hold && expected_codes.size() > 0)) begin
					byte_in <= text_stream[0].data;
					text_stream.pop_front();
					next_in_valid = 1'b1;
				end
			end
		end
		in_valid <= next_in_valid;
	end

	// output side: random stalls, compare each transaction with the oldest expectation
	always @(posedge clk) begin
		next_out_ready = out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{column, value_index, status, last};
				if (expected_codes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result col=%0d idx=%0d st=%0d last=%0b",
							$time, column, value_index, status, last);
				end else begin
					want = expected_codes.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp col=%0d idx=%0d st=%0d last=%0b",
								" got col=%0d idx=%0d st=%0d last=%0b"}, $time,
								want.column, want.value_index, want.status, want.last,
								column, value_index, status, last);
					end
				end
				stall_left     = draw_gap();
				next_out_ready = (stall_left == 0);
			end else if (!out_ready) begin
				if (stall_left > 0)
					stall_left--;
				if (stall_left == 0)
					next_out_ready = 1'b1;
			end
		end
		out_ready <= next_out_ready;
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic add_byte(input logic [7:0] b, input bit hold = 1'b0);
		text_byte_t t;
		t.data = b;
		t.hold = hold;
		text_stream.push_back(t);
	endtask

	function automatic logic [7:0] rand_token_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (is_break_byte(b));
		return b;
	endfunction

	task automatic add_break();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: add_byte(SEP_SPACE);
				1: add_byte(SEP_COMMA);
				2: add_byte(SEP_TAB);
				default: add_byte(SEP_CR);
			endcase
		end
	endtask

	task automatic add_token();
		int r;
		int idx;
		int n;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			idx = $urandom_range(0, POOL_SIZE - 1);
			for (int i = 0; i < pool_len[idx]; i++)
				add_byte(pool_word[idx][8*i +: 8]);
		end else begin
			n = (r < 90) ? $urandom_range(1, TOK_MAX) : $urandom_range(TOK_MAX + 1, TOK_MAX + 4);
			repeat (n) add_byte(rand_token_byte());
		end
	endtask

	// one row: mostly well-formed, sometimes short, long or raw noise
	task automatic add_row(input bit hold);
		int ntok;
		int eff;
		int n;
		if (hold)
			add_byte(SEP_CR, 1'b1);
		if ($urandom_range(0, 19) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
			return;
		end
		eff = active_columns();
		if ($urandom_range(0, 3) != 0 && eff > 0)
			ntok = eff;
		else
			ntok = $urandom_range(0, eff + 2);
		if ($urandom_range(0, 4) == 0)
			add_break();
		for (int k = 0; k < ntok; k++) begin
			add_token();
			if (k < ntok - 1 || $urandom_range(0, 3) == 0)
				add_break();
		end
		add_byte(SEP_LF);
	endtask

	task automatic write_columns(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ncols_cfg = v;
	endtask

	task automatic wait_idle();
		while (text_stream.size() > 0 || in_valid || expected_codes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] phase_cols[8];
		int               start_len;
		tok_word   = '0;
		tok_len    = 0;
		tok_ovf    = 1'b0;
		row_col    = 0;
		ncols_cfg  = 5'd1;
		mismatches = 0;
		send_wait  = 0;
		stall_left = 0;
		quiet_cycles = 0;
		no_idle    = 1'b0;
		foreach (dict_cnt[c]) dict_cnt[c] = 0;

		for (int p = 0; p < POOL_SIZE; p++) begin
			pool_word[p] = '0;
			pool_len[p]  = $urandom_range(1, TOK_MAX);
			for (int i = 0; i < pool_len[p]; i++)
				pool_word[p][8*i +: 8] = rand_token_byte();
		end
		// same bytes as entry 0 with a trailing NUL: differs only in length
		pool_len[0]  = 3;
		pool_word[0][63:24] = '0;
		pool_word[1] = pool_word[0];
		pool_len[1]  = 4;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_columns(5'd3);
		// empty row, token then short row, NUL token, overlong token, extra column
		add_byte(SEP_LF);
		add_byte("A");
		add_byte(SEP_LF);
		add_byte(8'h00);
		add_byte("A");
		add_byte(SEP_TAB);
		add_byte(SEP_CR);
		repeat (TOK_MAX + 1) add_byte(8'hFF);
		add_byte(SEP_SPACE);
		add_byte("A");
		add_byte(SEP_COMMA);
		add_byte("Z");
		add_byte(SEP_SPACE);
		add_byte(SEP_LF);
		add_byte("A");
		add_byte(SEP_LF, 1'b1);
		wait_idle();

		phase_cols = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd4};
		for (int ph = 0; ph < 12; ph++) begin
			write_columns(ph < 8 ? phase_cols[ph] : CFG_W'($urandom_range(1, 16)));
			no_idle   = (ph % 3 == 1);
			start_len = text_stream.size();
			add_row(1'b1);
			while (text_stream.size() - start_len < PHASE_BYTES)
				add_row($urandom_range(0, 39) == 0);
			wait_idle();
		end

		if (mismatches == 0 && expected_codes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
src/cdenc_pkg.sv
src/cdenc_front.sv
src/cdenc_queue.sv
src/cdenc_back.sv
src/csv_column_dictionary_encoder_top.sv
test/tb_csv_column_dictionary_encoder_top.sv
